// ===== hdl/mrr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mrr_pkg;

	localparam int MAX_DIM = 64;
	localparam int COORD_W = 6;
	localparam int DIM_W   = 7;
	localparam int ROT_W   = 30;
	localparam int LEN_W   = 9;
	localparam int CNT_W   = 5;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	localparam logic [1:0] CFG_ROWS     = 2'd0;
	localparam logic [1:0] CFG_COLS     = 2'd1;
	localparam logic [1:0] CFG_ROTATION = 2'd2;

	localparam logic [DIM_W-1:0] ROWS_RESET = 7'd2;
	localparam logic [DIM_W-1:0] COLS_RESET = 7'd2;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_GEOM = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_MAP  = 6'b001000,
		ST_RD   = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/matrix_ring_rotation.sv =====
// Write item: taken while idle, no result.
// Read item: the result is offered after ST_GEOM, ST_DIV, ST_MAP, ST_RD and ST_DONE; the
// 30-step remainder of the rotation by the ring length runs one quotient bit per cycle.
// A centre-line read skips ST_DIV and ST_MAP; an outside read goes straight to ST_DONE.
// ST_DONE waits on a stalled earlier result; the next item can be taken as the result appears.
// Reset clears the control state and sets rows and cols to 2 and rotation to 0.
`timescale 1ns / 1ps
`default_nettype none

module matrix_ring_rotation import mrr_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire [1:0]          cfg_index,
	input  wire [ROT_W-1:0]    cfg_data,
	input  wire                s_tvalid,
	output logic               s_tready,
	// row, col, value
	input  wire [((2*COORD_W+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	// action
	input  wire                s_tuser,
	output logic               m_tvalid,
	input  wire                m_tready,
	// value_out
	output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata,
	// out_of_range
	output logic               m_tuser
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

	logic [DIM_W-1:0] rows_q, cols_q;
	logic [ROT_W-1:0] rot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
			rot_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS:     rows_q <= cfg_data[DIM_W-1:0];
				CFG_COLS:     cols_q <= cfg_data[DIM_W-1:0];
				CFG_ROTATION: rot_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	logic [DIM_W-1:0] nr, nc;
	always_comb begin
		nr = ({2'b00, rows_q} > 9'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_q;
		nc = ({2'b00, cols_q} > 9'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_q;
	end

	logic [COORD_W-1:0]    in_row, in_col;
	logic [VALUE_BITS-1:0] in_value;
	logic                  in_inside, in_acc;
	assign in_row    = s_tdata[COORD_W-1:0];
	assign in_col    = s_tdata[2*COORD_W-1:COORD_W];
	assign in_value  = s_tdata[2*COORD_W+VALUE_BITS-1:2*COORD_W];
	assign in_inside = ({1'b0, in_row} < nr) && ({1'b0, in_col} < nc);
	assign in_acc    = s_tvalid && s_tready;

	state_t state_q;
	logic [COORD_W-1:0] r_q, c_q;
	logic               oor_q;
	logic [DIM_W-1:0]   d_q, a_q, b_q;
	logic [LEN_W-1:0]   len_q, p_q, rem_q;
	logic [ROT_W-1:0]   div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [AW-1:0]      addr_q;
	logic [VALUE_BITS-1:0] rd_data_q;
	logic [VALUE_BITS-1:0] mem [DEPTH];

	assign s_tready = (state_q == ST_IDLE);

	// Ring geometry of the requested cell.
	logic [DIM_W-1:0] r7, c7, e_bot, e_rgt, m1, m2, d, h, w, a, b, lr, lc;
	logic             degen;
	logic [LEN_W-1:0] len, p;
	always_comb begin
		r7    = {1'b0, r_q};
		c7    = {1'b0, c_q};
		e_bot = nr - 7'd1 - r7;
		e_rgt = nc - 7'd1 - c7;
		m1    = (r7 < c7) ? r7 : c7;
		m2    = (e_bot < e_rgt) ? e_bot : e_rgt;
		d     = (m1 < m2) ? m1 : m2;
		h     = nr - {d[DIM_W-2:0], 1'b0};
		w     = nc - {d[DIM_W-2:0], 1'b0};
		degen = (h <= 7'd1) || (w <= 7'd1);
		a     = h - 7'd1;
		b     = w - 7'd1;
		lr    = r7 - d;
		lc    = c7 - d;
		len   = {1'b0, a, 1'b0} + {1'b0, b, 1'b0};
		if (lc == '0)
			p = LEN_W'(lr);
		else if (lr == a)
			p = LEN_W'(a) + LEN_W'(lc);
		else if (lc == b)
			p = LEN_W'(a) + LEN_W'(b) + LEN_W'(a - lr);
		else
			p = {1'b0, a, 1'b0} + LEN_W'(b) + LEN_W'(b - lc);
	end

	// One restoring remainder step.
	logic [LEN_W:0]   trial;
	logic [LEN_W-1:0] rem_next;
	always_comb begin
		trial    = {rem_q, div_q[ROT_W-1]};
		rem_next = (trial >= {1'b0, len_q}) ? LEN_W'(trial - {1'b0, len_q}) : trial[LEN_W-1:0];
	end

	// Source position on the ring.
	logic [LEN_W:0]   diff;
	logic [LEN_W-1:0] s, ab, aab;
	logic [DIM_W-1:0] sr, sc, src_r, src_c;
	logic [AW-1:0]    src_addr, wr_addr;
	always_comb begin
		diff = {1'b0, p_q} - {1'b0, rem_q};
		s    = diff[LEN_W] ? LEN_W'(diff + {1'b0, len_q}) : diff[LEN_W-1:0];
		ab   = LEN_W'(a_q) + LEN_W'(b_q);
		aab  = ab + LEN_W'(a_q);
		if (s <= LEN_W'(a_q)) begin
			sr = DIM_W'(s);
			sc = '0;
		end else if (s <= ab) begin
			sr = a_q;
			sc = DIM_W'(s - LEN_W'(a_q));
		end else if (s <= aab) begin
			sr = DIM_W'(aab - s);
			sc = b_q;
		end else begin
			sr = '0;
			sc = DIM_W'(aab + LEN_W'(b_q) - s);
		end
		src_r    = sr + d_q;
		src_c    = sc + d_q;
		src_addr = AW'(AW'(src_r) * AW'(MAX_DIM) + AW'(src_c));
		wr_addr  = AW'(AW'(in_row) * AW'(MAX_DIM) + AW'(in_col));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_DONE)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc && s_tuser == ACT_READ)
					state_q <= in_inside ? ST_GEOM : ST_DONE;
				ST_GEOM: state_q <= degen ? ST_RD : ST_DIV;
				ST_DIV:  if (cnt_q == '0)
					state_q <= ST_MAP;
				ST_MAP:  state_q <= ST_RD;
				ST_RD:   state_q <= ST_DONE;
				ST_DONE: if (!m_tvalid || m_tready) begin
					m_tvalid <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			r_q   <= in_row;
			c_q   <= in_col;
			oor_q <= !in_inside;
		end
		if (state_q == ST_GEOM) begin
			d_q    <= d;
			a_q    <= a;
			b_q    <= b;
			len_q  <= len;
			p_q    <= p;
			rem_q  <= '0;
			div_q  <= rot_q;
			cnt_q  <= CNT_W'(ROT_W - 1);
			addr_q <= AW'(AW'(r_q) * AW'(MAX_DIM) + AW'(c_q));
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			div_q <= {div_q[ROT_W-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (state_q == ST_MAP)
			addr_q <= src_addr;
		if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
			m_tdata <= oor_q ? '0 : OUT_W'(rd_data_q);
			m_tuser <= oor_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == ACT_WRITE && in_inside)
			mem[wr_addr] <= in_value;
		if (state_q == ST_RD)
			rd_data_q <= mem[addr_q];
	end

endmodule

`default_nettype wire

// ===== hdl/mrr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrr_checker import mrr_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input wire clk,
	input wire arst_n,
	input wire s_tvalid,
	input wire s_tready,
	input wire s_tuser,
	input wire m_tvalid,
	input wire m_tready,
	input wire [((VALUE_BITS+7)/8)*8-1:0] m_tdata,
	input wire m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result item changed.");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("Out-of-range result carries a non-zero value.");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_WRITE && !m_tvalid |=> !m_tvalid)
		else $error("Write item produced a result.");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_READ |=> !s_tready)
		else $error("Input taken again straight after a read item.");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("Result appeared while the block was idle.");

endmodule

bind matrix_ring_rotation mrr_checker #(.VALUE_BITS(VALUE_BITS)) u_mrr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/matrix_ring_rotation_tb.sv =====
`timescale 1ns / 1ps

module matrix_ring_rotation_tb;
	import mrr_pkg::*;

	localparam int VALUE_BITS     = 32;
	localparam int S_W            = ((2*COORD_W+VALUE_BITS+7)/8)*8;
	localparam int M_W            = ((VALUE_BITS+7)/8)*8;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_PRINTS     = 40;
	localparam int ROT_MAX        = 32'h3FFF_FFFF;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  out_of_range;
	} rotated_word_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [ROT_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [S_W-1:0]   s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [M_W-1:0]   m_tdata;
	logic             m_tuser;

	logic [VALUE_BITS-1:0] element_mem [MAX_DIM*MAX_DIM];
	bit                    written     [MAX_DIM*MAX_DIM];
	int                    used_rows;
	int                    used_cols;
	int                    ring_steps;
	rotated_word_t         pending_reads [$];
	int                    errors;
	int                    idle_cycles;
	bit                    no_idle;
	bit                    hold_off;

	matrix_ring_rotation #(
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int dim_cap(int v);
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

	function automatic bit in_matrix(int r, int c);
		return (r < dim_cap(used_rows)) && (c < dim_cap(used_cols));
	endfunction

	// Address of the original element that lands on (r, c) once every ring is turned.
	function automatic int source_index(int r, int c);
		int nr, nc, d, h, w, lr, lc, a, b, len, p, s, sr, sc;
		nr = dim_cap(used_rows);
		nc = dim_cap(used_cols);
		d = r;
		if (c < d) d = c;
		if (nr - 1 - r < d) d = nr - 1 - r;
		if (nc - 1 - c < d) d = nc - 1 - c;
		h = nr - 2*d;
		w = nc - 2*d;
		if (h <= 1 || w <= 1)
			return r*MAX_DIM + c;
		lr = r - d;
		lc = c - d;
		a = h - 1;
		b = w - 1;
		len = 2*a + 2*b;
		if (lc == 0)
			p = lr;
		else if (lr == a)
			p = a + lc;
		else if (lc == b)
			p = a + b + (a - lr);
		else
			p = 2*a + b + (b - lc);
		s = (p + len - (ring_steps % len)) % len;
		if (s <= a) begin
			sr = s;
			sc = 0;
		end else if (s <= a + b) begin
			sr = a;
			sc = s - a;
		end else if (s <= 2*a + b) begin
			sr = a - (s - a - b);
			sc = b;
		end else begin
			sr = 0;
			sc = b - (s - 2*a - b);
		end
		return (sr + d)*MAX_DIM + (sc + d);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, wanted);
	endtask

	task automatic send_item(logic act, int r, int c, logic [VALUE_BITS-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(S_W-2*COORD_W-VALUE_BITS){1'b0}}, v, COORD_W'(c), COORD_W'(r)};
		do @(posedge clk); while (!s_tready);
		if (in_matrix(r, c)) begin
			if (act == ACT_WRITE) begin
				element_mem[r*MAX_DIM + c] = v;
				written[r*MAX_DIM + c] = 1'b1;
			end else begin
				pending_reads.push_back(rotated_word_t'{value: element_mem[source_index(r, c)],
					out_of_range: 1'b0});
			end
		end else if (act == ACT_READ) begin
			pending_reads.push_back(rotated_word_t'{value: '0, out_of_range: 1'b1});
		end
	endtask

	// A read never touches an element that has not been loaded: the source is written first.
	task automatic read_at(int r, int c);
		int src;
		if (in_matrix(r, c)) begin
			src = source_index(r, c);
			if (!written[src])
				send_item(ACT_WRITE, src / MAX_DIM, src % MAX_DIM, $urandom);
		end
		send_item(ACT_READ, r, c, $urandom);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(int nr, int nc, int steps);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data  <= ROT_W'(nr);
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data  <= ROT_W'(nc);
		@(posedge clk);
		cfg_index <= CFG_ROTATION;
		cfg_data  <= ROT_W'(steps);
		@(posedge clk);
		cfg_we     <= 1'b0;
		used_rows  = nr & 'h7F;
		used_cols  = nc & 'h7F;
		ring_steps = steps & ROT_MAX;
	endtask

	task automatic random_ops(int count);
		int nr, nc, r, c;
		nr = dim_cap(used_rows);
		nc = dim_cap(used_cols);
		repeat (count) begin
			if (nr > 0 && nc > 0 && $urandom_range(0, 99) < 88) begin
				r = $urandom_range(0, nr - 1);
				c = $urandom_range(0, nc - 1);
			end else begin
				r = $urandom_range(0, MAX_DIM - 1);
				c = $urandom_range(0, MAX_DIM - 1);
			end
			if ($urandom_range(0, 99) < 30)
				send_item(ACT_WRITE, r, c, $urandom);
			else
				read_at(r, c);
		end
	endtask

	task automatic test_reset_state();
		send_item(ACT_WRITE, 0, 0, '0);
		send_item(ACT_WRITE, 0, 1, '1);
		send_item(ACT_WRITE, 1, 0, 32'hA5A5_A5A5);
		send_item(ACT_WRITE, 1, 1, 32'h5A5A_5A5A);
		read_at(0, 0);
		read_at(0, 1);
		read_at(1, 0);
		read_at(1, 1);
		read_at(63, 63);
		send_item(ACT_WRITE, 2, 0, 32'h1234_5678);
		read_at(2, 0);
	endtask

	task automatic test_ring_shapes();
		configure(4, 6, 1);
		read_at(0, 0);
		read_at(3, 5);
		read_at(1, 2);
		configure(5, 3, ROT_MAX);
		read_at(2, 1);
		read_at(1, 1);
		read_at(0, 2);
		configure(3, 7, 2);
		read_at(1, 3);
		read_at(2, 6);
	endtask

	task automatic test_odd_sizes();
		configure(0, 5, 3);
		send_item(ACT_WRITE, 0, 0, 32'hDEAD_BEEF);
		read_at(0, 0);
		configure(1, 6, 9);
		read_at(0, 5);
		read_at(0, 0);
		configure(100, 127, 4);
		read_at(63, 63);
		read_at(0, 63);
		read_at(31, 32);
	endtask

	task automatic test_random_sizes();
		int nr, nc, steps, pick;
		for (int phase = 0; phase < 14; phase++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				nr = $urandom_range(2, 10);
				nc = $urandom_range(2, 10);
			end else if (pick < 80) begin
				nr = $urandom_range(2, 64);
				nc = $urandom_range(2, 64);
			end else if (pick < 88) begin
				nr = 64;
				nc = 64;
			end else begin
				nr = $urandom_range(0, 127);
				nc = $urandom_range(0, 1);
			end
			pick = $urandom_range(0, 99);
			if (pick < 15)
				steps = 0;
			else if (pick < 25)
				steps = ROT_MAX;
			else if (pick < 50)
				steps = $urandom_range(0, 300);
			else
				steps = $urandom_range(0, ROT_MAX);
			configure(nr, nc, steps);
			no_idle = (phase % 4 == 3);
			random_ops(120);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_output_stall();
		configure(6, 9, 5);
		no_idle  = 1'b1;
		hold_off = 1'b1;
		repeat (40) read_at($urandom_range(0, 5), $urandom_range(0, 8));
		settle();
		no_idle = 1'b0;
		random_ops(60);
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_ROWS;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = ACT_WRITE;
		used_rows  = ROWS_RESET;
		used_cols  = COLS_RESET;
		ring_steps = 0;
		errors     = 0;
		no_idle    = 1'b0;
		hold_off   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_ring_shapes();
		test_odd_sizes();
		test_output_stall();
		test_random_sizes();
		settle();
		if (errors == 0)
			$display("PASS matrix_ring_rotation");
		else
			$display("FAIL matrix_ring_rotation");
		$finish;
	end

	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
				m_tready <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				stall = no_idle ? 0 : $urandom_range(0, 14);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		rotated_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, '0);
			end else begin
				want = pending_reads.pop_front();
				if (m_tdata !== want.value)
					report_mismatch("value_out", m_tdata, want.value);
				if (m_tuser !== want.out_of_range)
					report_mismatch("out_of_range", m_tuser, want.out_of_range);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL matrix_ring_rotation");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
hdl/mrr_pkg.sv
hdl/matrix_ring_rotation.sv
hdl/mrr_checker.sv
tb/sv/matrix_ring_rotation_tb.sv
